// ===== hdl/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// shared widths, codes and controller/datapath interface types for the
// playback position advance unit
// ----------------------------------------------------------------------------
package ppa_pkg;

  // field widths
  localparam int TIME_BITS       = 48;
  localparam int SPEED_BITS      = 24;
  localparam int SPEED_FRAC_BITS = 16;
  localparam int ELAPSED_BITS    = 32;
  localparam int MODE_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = (TIME_BITS > SPEED_BITS) ? TIME_BITS : SPEED_BITS;

  // derived arithmetic widths
  localparam int PROD_BITS = SPEED_BITS + ELAPSED_BITS;
  localparam int MV_BITS   = PROD_BITS - SPEED_FRAC_BITS;
  // position after a move, signed
  localparam int XW        = ((TIME_BITS > MV_BITS) ? TIME_BITS : MV_BITS) + 2;
  // room for the reflection 2*edge - x
  localparam int RW        = XW + 2;
  // distance from start, and its magnitude fed to the divider
  localparam int DW        = XW + 1;
  // partial remainder of the bit-serial modulo
  localparam int REM_W     = TIME_BITS + 1;
  localparam int CNT_W     = $clog2(DW);

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((ELAPSED_BITS + TIME_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((TIME_BITS + 2 + 7) / 8) * 8;

  // play modes
  localparam logic [MODE_BITS-1:0] MODE_SINGLE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOOP   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BOUNCE = 2'd2;

  // opcodes
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_SEEK    = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_END   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED = 8'd3;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(1) << SPEED_FRAC_BITS;

  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_move;
    logic do_mode;
    logic div_step;
    logic do_fix;
    logic commit;
  } ppa_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } ppa_status_t;

endpackage

// ===== hdl/playback_position_advance_unit.sv =====
// ----------------------------------------------------------------------------
// playback_position_advance_unit
// playback position counter: advances by elapsed time times speed, then
// clamps, loops or reflects into the playable range; seeks clamp and set
// the direction
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ---------------------------------
//  s_axis    in   s_axis_tvalid/tready    tuser opcode, tdata operands
//  m_axis    out  m_axis_tvalid/tready    tdata position, direction, changed
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  an advance word steps from accept through multiply, move, range mode and
//  write; a loop-mode wrap adds the restoring modulo unit, one quotient bit
//  per cycle over 51 bits, and a fixup step before the write; a seek goes
//  through the same steps as an advance
//  s_axis_tready is high only while the sequencer is idle; a finished
//  result sits in the output register, so the next word is taken while it
//  waits, and write-back stalls only if a second result is ready first
//  rst is synchronous, active high: position 0, forward, speed 1.0,
//  range [0,0], single shot mode; cfg_ready is always high
//
module playback_position_advance_unit
  import ppa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // input words
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // elapsed [31:0], seek_time [79:32], seek_forward [80], zero pad
  input  logic [IN_DATA_BITS-1:0]    s_axis_tdata,
  // opcode [0]
  input  logic                       s_axis_tuser,
  // result words
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // position [47:0], moving_forward [48], changed [49], zero pad
  output logic [OUT_DATA_BITS-1:0]   m_axis_tdata,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  ppa_cmd_t    cmd;
  ppa_status_t status;

  logic signed [TIME_BITS-1:0] out_position;
  logic                        out_moving_forward;
  logic                        out_changed;

  // registers are always writable
  assign cfg_ready = 1'b1;

  ppa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ppa_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (s_axis_tuser),
    .in_elapsed         (s_axis_tdata[ELAPSED_BITS-1:0]),
    .in_seek_time       ($signed(s_axis_tdata[ELAPSED_BITS +: TIME_BITS])),
    .in_seek_forward    (s_axis_tdata[ELAPSED_BITS + TIME_BITS]),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_position       (out_position),
    .out_moving_forward (out_moving_forward),
    .out_changed        (out_changed)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata = OUT_DATA_BITS'({out_changed, out_moving_forward, out_position});

  // one word in flight: after an accept, no second accept until write-back
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second input word accepted while one is in flight");

  // write-back only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("result written over an untaken result");

  // a commit always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // the sequencer issues at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

// ===== hdl/ppa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppa_ctrl
// sequencer: steps one word through multiply, move, range mode, optional
// bit-serial modulo and write-back
// ----------------------------------------------------------------------------
module ppa_ctrl
  import ppa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output ppa_cmd_t    cmd,
  input  ppa_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_MODE  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.do_move = 1'b1;
        state_next  = S_MODE;
      end
      S_MODE: begin
        cmd.do_mode = 1'b1;
        state_next  = status.need_div ? S_DIV : S_WRITE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.do_fix = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/ppa_dp.sv =====
// ----------------------------------------------------------------------------
// ppa_dp
// datapath: registers, speed multiplier, move adder, range mode logic,
// restoring modulo unit and output register
// ----------------------------------------------------------------------------
module ppa_dp
  import ppa_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  ppa_cmd_t                         cmd,
  output ppa_status_t                      status,
  // configuration
  input  logic                             cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  // input word fields
  input  logic                             in_opcode,
  input  logic [ELAPSED_BITS-1:0]          in_elapsed,
  input  logic signed [TIME_BITS-1:0]      in_seek_time,
  input  logic                             in_seek_forward,
  // result word
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [TIME_BITS-1:0]      out_position,
  output logic                             out_moving_forward,
  output logic                             out_changed
);

  // configuration registers
  logic signed [TIME_BITS-1:0] start_time;
  logic signed [TIME_BITS-1:0] end_time;
  logic [MODE_BITS-1:0]        play_mode;
  logic [SPEED_BITS-1:0]       speed;

  // block state
  logic signed [TIME_BITS-1:0] position;
  logic                        forward;

  // captured word
  logic                        opcode;
  logic [ELAPSED_BITS-1:0]     elapsed;
  logic signed [TIME_BITS-1:0] seek_time;
  logic                        seek_forward;

  // working registers
  logic [PROD_BITS-1:0]        prod;
  logic signed [XW-1:0]        x;
  logic                        x_fwd;
  logic signed [TIME_BITS-1:0] res;
  logic                        res_fwd;
  logic [TIME_BITS-1:0]        span;
  logic [DW-1:0]               dmag;
  logic                        d_neg;
  logic [REM_W-1:0]            rem;
  logic [CNT_W-1:0]            cnt;

  // move
  logic [PROD_BITS-1:0]        prod_rnd;
  logic [MV_BITS-1:0]          mv;
  logic signed [XW-1:0]        mv_x;
  logic signed [XW-1:0]        pos_x;

  // range mode
  logic signed [RW-1:0]        xr, sr, er, xb;
  logic                        below, above, fb;
  logic signed [TIME_BITS:0]   span_full;
  logic                        span_pos;
  logic signed [DW-1:0]        d;
  logic [DW-1:0]               d_abs;
  logic signed [TIME_BITS-1:0] mode_pos;
  logic                        mode_fwd;
  logic                        loop_mode;

  // modulo step and fixup
  logic [REM_W-1:0]            rem_shift;
  logic [TIME_BITS-1:0]        r_fix;

  function automatic logic signed [TIME_BITS-1:0] clamp_pos(
    input logic signed [RW-1:0] v,
    input logic signed [RW-1:0] lo,
    input logic signed [RW-1:0] hi
  );
    logic signed [TIME_BITS-1:0] o;
    if (v < lo) begin
      o = lo[TIME_BITS-1:0];
    end else if (v > hi) begin
      o = hi[TIME_BITS-1:0];
    end else begin
      o = v[TIME_BITS-1:0];
    end
    return o;
  endfunction

  // rounded half up move
  assign prod_rnd = prod + (PROD_BITS'(1) << (SPEED_FRAC_BITS - 1));
  assign mv       = prod_rnd[PROD_BITS-1:SPEED_FRAC_BITS];
  assign mv_x     = XW'(mv);
  assign pos_x    = XW'(position);

  assign xr    = RW'(x);
  assign sr    = RW'(start_time);
  assign er    = RW'(end_time);
  assign below = (xr < sr);
  assign above = (xr > er);

  assign span_full = (TIME_BITS + 1)'(end_time) - (TIME_BITS + 1)'(start_time);
  assign span_pos  = (span_full > 0);
  assign d         = DW'(x) - DW'(start_time);
  assign d_abs     = d[DW-1] ? DW'(-d) : DW'(d);
  assign loop_mode = (opcode == OP_ADVANCE) && (play_mode == MODE_LOOP);

  // reflect once at the crossed edge
  always_comb begin
    xb = xr;
    fb = x_fwd;
    if (play_mode == MODE_BOUNCE) begin
      if (below) begin
        xb = sr + sr - xr;
        fb = 1'b1;
      end else if (above) begin
        xb = er + er - xr;
        fb = 1'b0;
      end
    end
  end

  always_comb begin
    mode_fwd = x_fwd;
    if (opcode == OP_SEEK) begin
      mode_pos = clamp_pos(xr, sr, er);
    end else begin
      case (play_mode)
        MODE_LOOP: begin
          // in range stays, otherwise start (modulo overrides when span > 0)
          mode_pos = (!below && !above) ? x[TIME_BITS-1:0] : start_time;
        end
        MODE_BOUNCE: begin
          mode_pos = clamp_pos(xb, sr, er);
          mode_fwd = fb;
        end
        default: begin
          mode_pos = clamp_pos(xr, sr, er);
        end
      endcase
    end
  end

  assign rem_shift = {rem[REM_W-2:0], dmag[DW-1]};
  assign r_fix     = d_neg ? ((rem != '0) ? (span - rem[TIME_BITS-1:0]) : '0)
                           : rem[TIME_BITS-1:0];

  assign status.need_div = loop_mode && (below || above) && span_pos;
  assign status.div_last = (cnt == CNT_W'(DW - 1));
  assign status.out_free = !out_valid || out_ready;

  // configuration and state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= '0;
      play_mode  <= MODE_SINGLE;
      speed      <= SPEED_RESET;
      position   <= '0;
      forward    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START: start_time <= cfg_data[TIME_BITS-1:0];
          CFG_END:   end_time   <= cfg_data[TIME_BITS-1:0];
          CFG_MODE:  play_mode  <= cfg_data[MODE_BITS-1:0];
          CFG_SPEED: speed      <= cfg_data[SPEED_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        position  <= res;
        forward   <= res_fwd;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode       <= in_opcode;
      elapsed      <= in_elapsed;
      seek_time    <= in_seek_time;
      seek_forward <= in_seek_forward;
    end
    if (cmd.do_mul) begin
      prod <= PROD_BITS'(speed) * PROD_BITS'(elapsed);
    end
    if (cmd.do_move) begin
      if (opcode == OP_SEEK) begin
        x     <= XW'(seek_time);
        x_fwd <= seek_forward;
      end else begin
        x     <= forward ? (pos_x + mv_x) : (pos_x - mv_x);
        x_fwd <= forward;
      end
    end
    if (cmd.do_mode) begin
      res     <= mode_pos;
      res_fwd <= mode_fwd;
      span    <= span_full[TIME_BITS-1:0];
      d_neg   <= d[DW-1];
      dmag    <= d_abs;
      rem     <= '0;
      cnt     <= '0;
    end
    if (cmd.div_step) begin
      rem  <= (rem_shift >= REM_W'(span)) ? (rem_shift - REM_W'(span)) : rem_shift;
      dmag <= dmag << 1;
      cnt  <= cnt + CNT_W'(1);
    end
    if (cmd.do_fix) begin
      res <= start_time + $signed(r_fix);
    end
    if (cmd.commit) begin
      out_position       <= res;
      out_moving_forward <= res_fwd;
      out_changed        <= (res != position) || (res_fwd != forward);
    end
  end

endmodule

// ===== bench/playback_position_advance_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_position_advance_unit_tb
// self-checking bench: a queue-fed stream driver with bursty gaps, a
// stalling result sink and a bit-exact position predictor; directed words
// cover clamp, loop wrap, reflection, rounding and odd ranges, then random
// phases sweep range, mode and speed settings written while the unit idles
// ----------------------------------------------------------------------------
module playback_position_advance_unit_tb
  import ppa_pkg::*;
();

  // unused mode encoding, must act as single shot
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MIN   = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0] TIME_MAX   = {1'b0, {(TIME_BITS-1){1'b1}}};
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT = 5000;

  // wide enough that no move, wrap or reflection can overflow
  typedef logic signed [127:0] ext_time_t;

  typedef struct packed {
    logic                    op;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0]    seek_time;
    logic                    seek_fwd;
  } play_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] position;
    logic                 moving_forward;
    logic                 changed;
  } play_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_SPARSE} rx_kind_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
  logic                      s_axis_tuser = OP_ADVANCE;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // shadow of the register file and of the position state
  logic signed [TIME_BITS-1:0] range_start = '0;
  logic signed [TIME_BITS-1:0] range_end   = '0;
  logic [MODE_BITS-1:0]        mode_now    = MODE_SINGLE;
  logic [SPEED_BITS-1:0]       speed_now   = SPEED_RESET;
  logic [TIME_BITS-1:0]        pos_now     = '0;
  logic                        fwd_now     = 1'b1;

  play_word_t   pending_words[$];
  play_result_t due_results[$];
  int           mismatches = 0;

  always #10 clk = ~clk;

  playback_position_advance_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic ext_time_t clamp_to_range(ext_time_t x, ext_time_t lo, ext_time_t hi);
    if (x < lo) return lo;
    if (hi < x) return hi;
    return x;
  endfunction

  // one step of the position counter; updates the shadow state
  function automatic play_result_t advance_position(play_word_t w);
    ext_time_t    s;
    ext_time_t    e;
    ext_time_t    x;
    ext_time_t    mv;
    ext_time_t    span;
    ext_time_t    r;
    logic [127:0] prod;
    logic         fwd;
    play_result_t res;
    s   = ext_time_t'(range_start);
    e   = ext_time_t'(range_end);
    fwd = fwd_now;
    if (w.op == OP_SEEK) begin
      x   = clamp_to_range(ext_time_t'($signed(w.seek_time)), s, e);
      fwd = w.seek_fwd;
    end else begin
      // speed is Q8.16, move rounded half up
      prod = 128'(speed_now) * 128'(w.elapsed) + (128'(1) << (SPEED_FRAC_BITS - 1));
      mv   = $signed(prod >> SPEED_FRAC_BITS);
      x    = ext_time_t'($signed(pos_now));
      x    = fwd ? x + mv : x - mv;
      case (mode_now)
        MODE_LOOP: begin
          // inside [start,end] stays put, end included
          if (x < s || x > e) begin
            span = e - s;
            if (span <= 0) begin
              x = s;
            end else begin
              // true modulo, never negative when moving backward
              r = (x - s) % span;
              if (r < 0) r = r + span;
              x = s + r;
            end
          end
        end
        MODE_BOUNCE: begin
          // reflect once off the crossed edge, then clamp
          if (x < s) begin
            x   = s + s - x;
            fwd = 1'b1;
          end else if (x > e) begin
            x   = e + e - x;
            fwd = 1'b0;
          end
          x = clamp_to_range(x, s, e);
        end
        default: x = clamp_to_range(x, s, e);
      endcase
    end
    res.position       = x[TIME_BITS-1:0];
    res.moving_forward = fwd;
    res.changed        = (x[TIME_BITS-1:0] != pos_now) || (fwd != fwd_now);
    pos_now = x[TIME_BITS-1:0];
    fwd_now = fwd;
    return res;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic void queue_word(logic op, logic [ELAPSED_BITS-1:0] el,
                                     logic [TIME_BITS-1:0] tgt, logic dir);
    play_word_t w;
    w.op        = op;
    w.elapsed   = el;
    w.seek_time = tgt;
    w.seek_fwd  = dir;
    pending_words.push_back(w);
  endfunction

  // one register write; the shadow follows at the accepting edge
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START: range_start = data[TIME_BITS-1:0];
      CFG_END:   range_end   = data[TIME_BITS-1:0];
      CFG_MODE:  mode_now    = data[MODE_BITS-1:0];
      CFG_SPEED: speed_now   = data[SPEED_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // full register set plus a write to an unmapped index; upper data bits
  // above each register width carry noise
  task automatic configure(input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi,
                           input logic [MODE_BITS-1:0] mode,
                           input logic [SPEED_BITS-1:0] rate);
    logic [CFG_DATA_BITS-1:0] noise;
    noise = rand_time();
    write_reg(CFG_START, lo);
    write_reg(CFG_END, hi);
    write_reg(CFG_MODE, {noise[CFG_DATA_BITS-1:MODE_BITS], mode});
    noise = rand_time();
    write_reg(CFG_SPEED, {noise[CFG_DATA_BITS-1:SPEED_BITS], rate});
    write_reg(CFG_INDEX_BITS'($urandom_range(4, 255)), rand_time());
    @(negedge clk);
  endtask

  // idle means every word taken and every result back; sampled mid-cycle
  task automatic drain_words();
    @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // stream driver: bursts of words with random gaps between bursts
  int burst_left = 0;
  int gap_left   = 0;
  play_word_t cur_word;

  always @(posedge clk) begin : drive_words
    int roll;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(advance_position(cur_word));
      end
      // free to present the next word
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_BITS'({cur_word.seek_fwd, cur_word.seek_time,
                                          cur_word.elapsed});
          s_axis_tuser  <= cur_word.op;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            // gap lengths spread over the whole modulo run
            roll = $urandom_range(0, 9);
            if (roll < 4)       gap_left = 0;
            else if (roll < 7)  gap_left = $urandom_range(1, 8);
            else if (roll < 9)  gap_left = $urandom_range(9, 70);
            else                gap_left = $urandom_range(71, 120);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink: switches at random between open, coin-flip, hold and sparse stalls
  rx_kind_t rx_kind = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin : sink_stalls
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_kind = rx_kind_t'($urandom_range(0, 3));
        rx_left = (rx_kind == RX_HOLD) ? $urandom_range(1, 300) : $urandom_range(20, 400);
      end else begin
        rx_left--;
      end
      case (rx_kind)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_HOLD:  m_axis_tready <= 1'b0;
        default:  m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker against the oldest due result
  always @(posedge clk) begin : check_results
    play_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result word with nothing due, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[TIME_BITS-1:0] != want.position) begin
          $display("%0t: position expected %h actual %h", $time, want.position,
                   m_axis_tdata[TIME_BITS-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[TIME_BITS] != want.moving_forward) begin
          $display("%0t: moving_forward expected %b actual %b", $time, want.moving_forward,
                   m_axis_tdata[TIME_BITS]);
          mismatches++;
        end
        if (m_axis_tdata[TIME_BITS+1] != want.changed) begin
          $display("%0t: changed expected %b actual %b", $time, want.changed,
                   m_axis_tdata[TIME_BITS+1]);
          mismatches++;
        end
      end
    end
  end

  // hang detector
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("playback_position_advance_unit_tb: FAIL");
    $finish;
  end

  initial begin : run_phases
    int                    ph;
    int                    n;
    play_word_t            w;
    logic [TIME_BITS-1:0]  lo;
    logic [TIME_BITS-1:0]  hi;
    logic [SPEED_BITS-1:0] rate;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty range at zero, single shot, speed 1.0
    queue_word(OP_ADVANCE, '0, '0, 1'b0);
    queue_word(OP_ADVANCE, '1, '0, 1'b0);
    queue_word(OP_SEEK, '0, TIME_MAX, 1'b0);
    queue_word(OP_SEEK, '1, TIME_MIN, 1'b1);
    drain_words();

    // single shot clamps at both ends
    configure(-48'sd1000, 48'sd1000, MODE_SINGLE, SPEED_RESET);
    queue_word(OP_ADVANCE, 32'd500, '0, 1'b0);
    queue_word(OP_ADVANCE, 32'd2000, '0, 1'b0);
    queue_word(OP_SEEK, '0, -48'sd200, 1'b0);
    queue_word(OP_ADVANCE, 32'd5000, '0, 1'b0);
    drain_words();

    // loop: forward wrap, landing on end, backward wrap, huge move
    configure(-48'sd1000, 48'sd1000, MODE_LOOP, SPEED_RESET);
    queue_word(OP_SEEK, '0, 48'sd900, 1'b1);
    queue_word(OP_ADVANCE, 32'd300, '0, 1'b0);
    queue_word(OP_ADVANCE, 32'd1800, '0, 1'b0);
    queue_word(OP_SEEK, '0, -48'sd900, 1'b0);
    queue_word(OP_ADVANCE, 32'd300, '0, 1'b0);
    queue_word(OP_ADVANCE, '1, '0, 1'b0);
    drain_words();

    // back and forth: reflect off end, then overshoot past start
    configure(-48'sd1000, 48'sd1000, MODE_BOUNCE, SPEED_RESET);
    queue_word(OP_SEEK, '0, 48'sd900, 1'b1);
    queue_word(OP_ADVANCE, 32'd300, '0, 1'b0);
    queue_word(OP_ADVANCE, 32'd5000, '0, 1'b0);
    drain_words();

    // smallest speed: half a step rounds up, just under rounds down
    configure(-48'sd1000, 48'sd1000, MODE_SINGLE, 24'd1);
    queue_word(OP_SEEK, '0, '0, 1'b1);
    queue_word(OP_ADVANCE, 32'd32767, '0, 1'b0);
    queue_word(OP_ADVANCE, 32'd32768, '0, 1'b0);
    drain_words();

    // zero speed, no move
    configure(-48'sd1000, 48'sd1000, MODE_SINGLE, '0);
    queue_word(OP_ADVANCE, '1, '0, 1'b0);
    drain_words();

    // inverted range: loop falls to start, spare mode clamps like single
    configure(48'sd100, -48'sd100, MODE_LOOP, '1);
    queue_word(OP_ADVANCE, 32'd5, '0, 1'b0);
    drain_words();
    configure(48'sd100, -48'sd100, MODE_SPARE, '1);
    queue_word(OP_ADVANCE, 32'd5, '0, 1'b0);
    drain_words();

    // widest range at top speed, wrap then reflect
    configure(TIME_MIN, TIME_MAX, MODE_LOOP, '1);
    queue_word(OP_SEEK, '0, TIME_MAX, 1'b1);
    queue_word(OP_ADVANCE, '1, '0, 1'b0);
    drain_words();
    configure(TIME_MIN, TIME_MAX, MODE_BOUNCE, '1);
    queue_word(OP_ADVANCE, '1, '0, 1'b0);
    drain_words();

    // random phases, each with its own range, mode and speed
    for (ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          lo = TIME_BITS'($urandom_range(0, 4000)) - 48'd2000;
          hi = lo + TIME_BITS'($urandom_range(1, 3000));
        end
        1: begin
          lo = rand_time();
          hi = lo;
        end
        2: begin
          lo = TIME_BITS'($urandom_range(0, 4000)) - 48'd2000;
          hi = lo - TIME_BITS'($urandom_range(1, 1000));
        end
        3: begin
          lo = TIME_MIN;
          hi = TIME_MAX;
        end
        4: begin
          lo = rand_time();
          hi = rand_time();
        end
        default: begin
          lo = rand_time();
          hi = lo + TIME_BITS'($urandom);
        end
      endcase
      case ($urandom_range(0, 5))
        0:       rate = '0;
        1:       rate = 24'd1;
        2:       rate = SPEED_RESET;
        3:       rate = '1;
        4:       rate = SPEED_BITS'($urandom_range(0, 262144));
        default: rate = SPEED_BITS'($urandom);
      endcase
      // cycle the modes so each gets random phases
      configure(lo, hi, MODE_BITS'(ph), rate);
      for (n = 0; n < 60; n++) begin
        w.op       = ($urandom_range(0, 3) == 0) ? OP_SEEK : OP_ADVANCE;
        w.seek_fwd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0:       w.elapsed = '0;
          1:       w.elapsed = '1;
          2:       w.elapsed = $urandom;
          default: w.elapsed = ELAPSED_BITS'($urandom_range(0, 4000)) << $urandom_range(0, 12);
        endcase
        case ($urandom_range(0, 3))
          0:       w.seek_time = range_start + TIME_BITS'($urandom_range(0, 4000)) - 48'd1000;
          1:       w.seek_time = rand_time();
          2:       w.seek_time = TIME_MIN;
          default: w.seek_time = TIME_MAX;
        endcase
        pending_words.push_back(w);
      end
      drain_words();
    end

    // let any stray result show up before the verdict
    repeat (80) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("playback_position_advance_unit_tb: PASS");
    end else begin
      $display("playback_position_advance_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ppa_pkg.sv
hdl/ppa_ctrl.sv
hdl/ppa_dp.sv
hdl/playback_position_advance_unit.sv
bench/playback_position_advance_unit_tb.sv
